>>> rtl/aer_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aer_pkg
// Shared types and constants of the accept-encoding resolver: the classified
// byte record that travels from the front end through the queue to the parser.
// ----------------------------------------------------------------------------
package aer_pkg;

  // depth of the queue between classifier and parser
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // token position saturates at this value
  localparam logic [2:0] POS_MAX = 3'd7;

  localparam logic [2:0] POS_GZIP_LEN = 3'd4;
  localparam logic [2:0] POS_BR_LEN   = 3'd2;
  localparam logic [2:0] POS_STAR_LEN = 3'd1;

  // index 0 holds the first letter
  localparam logic [3:0][7:0] LIT_GZIP = '{8'h70, 8'h69, 8'h7a, 8'h67};
  localparam logic [1:0][7:0] LIT_BR   = '{8'h72, 8'h62};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LOW_Q = 8'h71;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // one classified header byte; all class flags are zero when has_char is low
  typedef struct packed {
    logic [7:0] lc;        // byte folded to lower case
    logic       has_char;
    logic       last;
    logic       blank;
    logic       comma;
    logic       semi;
    logic       eq;
    logic       is_q;
    logic       zero;
    logic       dot;
    logic       digit_nz;
    logic       star;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/accept_encoding_resolver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accept_encoding_resolver
// Streaming resolver for an Accept-Encoding header value: reports whether
// gzip and br are acceptable once the last byte of the header arrives.
// ----------------------------------------------------------------------------
// The block takes one header byte per cycle while in_stall is low, with no
// gaps of its own: a front end classifies the byte and writes it into a
// two-entry queue, and the parser behind it, a small state machine, consumes
// one byte per cycle unless a last byte waits on a held result. The result
// is registered once the last byte leaves the queue and stays until taken.
// Input stall rises only when the queue holds two bytes, which happens when
// the result register is still occupied as a further header ends; the parser
// then waits on the output side alone while the front end fills the queue.
module accept_encoding_resolver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  input  wire logic       has_char,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            gzip_ok,
  output logic            brotli_ok
);

  aer_pkg::item_t              q_wdata;
  aer_pkg::item_t              q_rdata;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_not_empty;
  logic                        q_full;
  logic [aer_pkg::QCNT_W-1:0]  q_count;

  aer_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .has_char (has_char),
    .last     (last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  aer_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  aer_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .gzip_ok     (gzip_ok),
    .brotli_ok   (brotli_ok)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= aer_pkg::QCNT_W'(aer_pkg::QDEPTH))
    else $error("queue count beyond depth");

  // a last byte never leaves the queue while a result is held back
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && q_pop) |-> !q_rdata.last)
    else $error("result register overwritten while stalled");

  // a transferred byte is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> q_not_empty)
    else $error("accepted byte missing from queue");

endmodule
`default_nettype wire

>>> rtl/aer_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aer_front
// Input side: classifies each header byte into the delimiter and character
// classes the parser needs, and pushes the record into the queue.
// ----------------------------------------------------------------------------
module aer_front (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    ch,
  input  wire logic          has_char,
  input  wire logic          last,
  input  wire logic          q_full,
  output logic               q_push,
  output aer_pkg::item_t     q_wdata
);

  logic is_upper;

  assign is_upper = (ch >= aer_pkg::CH_UP_A) && (ch <= aer_pkg::CH_UP_Z);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata          = '0;
    q_wdata.lc       = is_upper ? (ch | aer_pkg::CASE_BIT) : ch;
    q_wdata.has_char = has_char;
    q_wdata.last     = last;
    q_wdata.blank    = has_char && (ch == aer_pkg::CH_SPACE || ch == aer_pkg::CH_TAB);
    q_wdata.comma    = has_char && (ch == aer_pkg::CH_COMMA);
    q_wdata.semi     = has_char && (ch == aer_pkg::CH_SEMI);
    q_wdata.eq       = has_char && (ch == aer_pkg::CH_EQ);
    q_wdata.is_q     = has_char && ((ch | aer_pkg::CASE_BIT) == aer_pkg::CH_LOW_Q);
    q_wdata.zero     = has_char && (ch == aer_pkg::CH_ZERO);
    q_wdata.dot      = has_char && (ch == aer_pkg::CH_DOT);
    q_wdata.digit_nz = has_char && (ch >= aer_pkg::CH_ONE) && (ch <= aer_pkg::CH_NINE);
    q_wdata.star     = has_char && (ch == aer_pkg::CH_STAR);
  end

endmodule
`default_nettype wire

>>> rtl/aer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aer_queue
// Short first-in first-out queue of classified bytes between the front end
// and the parser.
// ----------------------------------------------------------------------------
module aer_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire aer_pkg::item_t              wdata,
  input  wire logic                        pop,
  output aer_pkg::item_t                   rdata,
  output logic                             not_empty,
  output logic                             full,
  output logic [aer_pkg::QCNT_W-1:0]       count
);

  aer_pkg::item_t                 slots [aer_pkg::QDEPTH];
  logic [aer_pkg::QPTR_W-1:0]     wr_ptr;
  logic [aer_pkg::QPTR_W-1:0]     rd_ptr;

  assign not_empty = (count != '0);
  assign full      = (count == aer_pkg::QCNT_W'(aer_pkg::QDEPTH));
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == aer_pkg::QPTR_W'(aer_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == aer_pkg::QPTR_W'(aer_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/aer_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aer_back
// Parser: walks the entry grammar one classified byte per cycle while no held
// result blocks a last byte, keeps per-coding verdicts, registers the result.
// ----------------------------------------------------------------------------
module aer_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_not_empty,
  input  wire aer_pkg::item_t q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                gzip_ok,
  output logic                brotli_ok
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_TOKEN,
    PH_PLEAD,
    PH_PNAME,
    PH_SKIP,
    PH_QLEAD,
    PH_QZERO,
    PH_QFRAC
  } phase_t;

  phase_t     phase, phase_next;
  logic [2:0] pos, pos_next;
  logic       cand_gz, cand_gz_next;
  logic       cand_br, cand_br_next;
  logic       cand_star, cand_star_next;
  logic       pend, pend_next;
  logic       pname_q, pname_q_next;
  logic       qzero, qzero_next;
  logic [5:0] verdicts, verdicts_next;
  logic       res_gz, res_br;
  logic       tok_byte;
  logic [1:0] entry_v;

  // a last byte needs the output register free or draining
  assign q_pop = q_not_empty && (!q_rdata.last || !out_valid || !out_stall);

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    cand_gz_next   = cand_gz;
    cand_br_next   = cand_br;
    cand_star_next = cand_star;
    pend_next      = pend;
    pname_q_next   = pname_q;
    qzero_next     = qzero;
    verdicts_next  = verdicts;
    tok_byte       = 1'b0;
    entry_v        = 2'b00;
    res_gz         = 1'b0;
    res_br         = 1'b0;

    if (q_rdata.has_char && !q_rdata.comma) begin
      if (q_rdata.semi) begin
        phase_next = PH_PLEAD;
      end else begin
        case (phase)
          PH_LEAD: begin
            if (!q_rdata.blank) begin
              phase_next = PH_TOKEN;
              tok_byte   = 1'b1;
            end
          end
          PH_TOKEN: begin
            if (q_rdata.blank) pend_next = 1'b1;
            else tok_byte = 1'b1;
          end
          PH_PLEAD: begin
            if (q_rdata.eq) begin
              phase_next = PH_SKIP;
            end else if (!q_rdata.blank) begin
              pname_q_next = q_rdata.is_q;
              phase_next   = PH_PNAME;
            end
          end
          PH_PNAME: begin
            if (q_rdata.eq) begin
              if (pname_q) begin
                phase_next = PH_QLEAD;
                qzero_next = 1'b0;
              end else begin
                phase_next = PH_SKIP;
              end
            end else begin
              pname_q_next = 1'b0;
            end
          end
          PH_QLEAD: begin
            if (q_rdata.zero) begin
              qzero_next = 1'b1;
              phase_next = PH_QZERO;
            end else if (!q_rdata.blank) begin
              phase_next = PH_SKIP;
            end
          end
          PH_QZERO: begin
            phase_next = q_rdata.dot ? PH_QFRAC : PH_SKIP;
          end
          PH_QFRAC: begin
            if (!q_rdata.zero) begin
              if (q_rdata.digit_nz) qzero_next = 1'b0;
              phase_next = PH_SKIP;
            end
          end
          PH_SKIP: begin
          end
          default: begin
            phase_next = PH_LEAD;
          end
        endcase
      end
    end

    // token character: blanks followed by more text kill every candidate
    if (tok_byte) begin
      if (pend) begin
        cand_gz_next   = 1'b0;
        cand_br_next   = 1'b0;
        cand_star_next = 1'b0;
      end else begin
        cand_gz_next   = cand_gz && (pos < aer_pkg::POS_GZIP_LEN) &&
                         (q_rdata.lc == aer_pkg::LIT_GZIP[pos[1:0]]);
        cand_br_next   = cand_br && (pos < aer_pkg::POS_BR_LEN) &&
                         (q_rdata.lc == aer_pkg::LIT_BR[pos[0]]);
        cand_star_next = cand_star && (pos == '0) && q_rdata.star;
      end
      if (pos != aer_pkg::POS_MAX) pos_next = pos + 1'b1;
    end

    // entry close on a comma or at the end of the header
    if (q_rdata.comma || q_rdata.last) begin
      entry_v = {!qzero_next, 1'b1};
      if (cand_gz_next && pos_next == aer_pkg::POS_GZIP_LEN) begin
        verdicts_next[1:0] = entry_v;
      end else if (cand_br_next && pos_next == aer_pkg::POS_BR_LEN) begin
        verdicts_next[3:2] = entry_v;
      end else if (cand_star_next && pos_next == aer_pkg::POS_STAR_LEN) begin
        verdicts_next[5:4] = entry_v;
      end
      phase_next     = PH_LEAD;
      pos_next       = '0;
      cand_gz_next   = 1'b1;
      cand_br_next   = 1'b1;
      cand_star_next = 1'b1;
      pend_next      = 1'b0;
      pname_q_next   = 1'b0;
      qzero_next     = 1'b0;
    end

    res_gz = verdicts_next[0] ? verdicts_next[1] : (verdicts_next[4] && verdicts_next[5]);
    res_br = verdicts_next[2] ? verdicts_next[3] : (verdicts_next[4] && verdicts_next[5]);

    if (q_rdata.last) begin
      verdicts_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      pos       <= '0;
      cand_gz   <= 1'b1;
      cand_br   <= 1'b1;
      cand_star <= 1'b1;
      pend      <= 1'b0;
      pname_q   <= 1'b0;
      qzero     <= 1'b0;
      verdicts  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && q_rdata.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        phase     <= phase_next;
        pos       <= pos_next;
        cand_gz   <= cand_gz_next;
        cand_br   <= cand_br_next;
        cand_star <= cand_star_next;
        pend      <= pend_next;
        pname_q   <= pname_q_next;
        qzero     <= qzero_next;
        verdicts  <= verdicts_next;
        if (q_rdata.last) begin
          gzip_ok   <= res_gz;
          brotli_ok <= res_br;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accept-encoding resolver. Header values go in
// one byte per transfer: a short set of hand-picked headers first, then random
// well-formed headers mixed with noise bytes and broken entries. A scoreboard
// parses the same bytes, predicts gzip_ok and brotli_ok for each header and
// checks every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 360;

  typedef enum {
    SCAN_LEAD, SCAN_TOKEN, SCAN_PARAM_LEAD, SCAN_PARAM_NAME,
    SCAN_SKIP, SCAN_Q_LEAD, SCAN_Q_ZERO, SCAN_Q_FRAC
  } scan_phase_t;

  typedef enum logic [1:0] {
    PNAME_NONE, PNAME_Q, PNAME_OTHER
  } pname_t;

  class encoding_scoreboard;
    scan_phase_t phase;
    bit [2:0]    tok_pos;
    bit          cand_gzip, cand_br, cand_star, pend_blank;
    pname_t      pname;
    bit          q_zero;
    bit          gz_seen, gz_acc, br_seen, br_acc, star_seen, star_acc;
    bit [1:0]    expected_verdicts[$];
    int          errors;
    string       gzip_name = "gzip";
    string       br_name = "br";

    function new();
      errors = 0;
      clear_header();
    endfunction

    function void clear_entry();
      phase = SCAN_LEAD;
      tok_pos = 0;
      cand_gzip = 1;
      cand_br = 1;
      cand_star = 1;
      pend_blank = 0;
      pname = PNAME_NONE;
      q_zero = 0;
    endfunction

    function void clear_header();
      clear_entry();
      {gz_seen, gz_acc, br_seen, br_acc, star_seen, star_acc} = '0;
    endfunction

    function bit is_blank(bit [7:0] c);
      return c == " " || c == "\t";
    endfunction

    function void token_byte(bit [7:0] c);
      bit [7:0] lc;
      lc = c;
      if (pend_blank) begin
        // a blank followed by more token bytes kills every match
        cand_gzip = 0;
        cand_br = 0;
        cand_star = 0;
      end else begin
        if (c >= "A" && c <= "Z") lc = c | 8'h20;
        if (tok_pos >= 4 || lc != gzip_name[tok_pos]) cand_gzip = 0;
        if (tok_pos >= 2 || lc != br_name[tok_pos]) cand_br = 0;
        if (tok_pos != 0 || c != "*") cand_star = 0;
      end
      if (tok_pos < 7) tok_pos++;
    endfunction

    function void finish_entry();
      bit acc;
      acc = !q_zero;
      if (cand_gzip && tok_pos == 4) begin
        gz_seen = 1;
        gz_acc = acc;
      end else if (cand_br && tok_pos == 2) begin
        br_seen = 1;
        br_acc = acc;
      end else if (cand_star && tok_pos == 1) begin
        star_seen = 1;
        star_acc = acc;
      end
      clear_entry();
    endfunction

    function bit take_delim(bit [7:0] c);
      if (c == ",") begin
        finish_entry();
        return 1;
      end
      if (c == ";") begin
        phase = SCAN_PARAM_LEAD;
        return 1;
      end
      return 0;
    endfunction

    function void scan_byte(bit [7:0] c);
      case (phase)
        SCAN_LEAD: begin
          if (!is_blank(c) && !take_delim(c)) begin
            phase = SCAN_TOKEN;
            token_byte(c);
          end
        end
        SCAN_TOKEN: begin
          if (!take_delim(c)) begin
            if (is_blank(c)) pend_blank = 1;
            else token_byte(c);
          end
        end
        SCAN_PARAM_LEAD: begin
          if (!is_blank(c) && !take_delim(c)) begin
            if (c == "=") begin
              phase = SCAN_SKIP;
            end else begin
              pname = (c == "q" || c == "Q") ? PNAME_Q : PNAME_OTHER;
              phase = SCAN_PARAM_NAME;
            end
          end
        end
        SCAN_PARAM_NAME: begin
          if (!take_delim(c)) begin
            if (c == "=") begin
              if (pname == PNAME_Q) begin
                phase = SCAN_Q_LEAD;
                q_zero = 0;
              end else begin
                phase = SCAN_SKIP;
              end
            end else begin
              pname = PNAME_OTHER;
            end
          end
        end
        SCAN_Q_LEAD: begin
          if (!is_blank(c)) begin
            if (c == "0") begin
              q_zero = 1;
              phase = SCAN_Q_ZERO;
            end else if (!take_delim(c)) begin
              phase = SCAN_SKIP;
            end
          end
        end
        SCAN_Q_ZERO: begin
          if (!take_delim(c)) phase = (c == ".") ? SCAN_Q_FRAC : SCAN_SKIP;
        end
        SCAN_Q_FRAC: begin
          if (!take_delim(c) && c != "0") begin
            if (c >= "1" && c <= "9") q_zero = 0;
            phase = SCAN_SKIP;
          end
        end
        default: begin
          void'(take_delim(c));
        end
      endcase
    endfunction

    // called for every input transfer
    function void note_byte(bit [7:0] c, bit h, bit l);
      bit gz, br;
      if (h) scan_byte(c);
      if (l) begin
        finish_entry();
        // explicit entries win over the wildcard
        gz = gz_seen ? gz_acc : (star_seen && star_acc);
        br = br_seen ? br_acc : (star_seen && star_acc);
        expected_verdicts.push_back({gz, br});
        clear_header();
      end
    endfunction

    function void check_verdict(bit gz, bit br);
      bit [1:0] want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual gzip_ok %0d brotli_ok %0d",
                 $time, gz, br);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (gz !== want[1]) begin
        $display("%0t: gzip_ok mismatch, expected %0d, actual %0d", $time, want[1], gz);
        errors++;
      end
      if (br !== want[0]) begin
        $display("%0t: brotli_ok mismatch, expected %0d, actual %0d", $time, want[0], br);
        errors++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] ch = 8'h00;
  logic       has_char = 1'b0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       gzip_ok;
  logic       brotli_ok;

  accept_encoding_resolver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .has_char  (has_char),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gzip_ok   (gzip_ok),
    .brotli_ok (brotli_ok)
  );

  encoding_scoreboard sb;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sent_items = 0;
  int quiet_cycles = 0;
  int phase_start;
  bit [7:0] hdr[$];

  string param_pool [18] = '{
    "q=0", "Q=0", "q=0.", "q=0.000", "q=0.5", "q=1", "q=0.01", "q=", "q= 0",
    "q=\t0.0", "q =0", "qq=0", "a=b", "=0", "q=0x", "q=0.00a", "q", "Q=1.000"
  };

  initial begin
    sb = new();
    forever #5 clk = ~clk;
  end

  // receiver side: random stall, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_verdict(gzip_ok, brotli_ok);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(bit [7:0] c, bit h, bit l);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    has_char <= h;
    last <= l;
    do @(posedge clk); while (in_stall);
    sb.note_byte(c, h, l);
    if (h || l) sent_items++;
    @(negedge clk);
  endtask

  task automatic send_header(bit [7:0] bytes[$], bit sep_end);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 99) < 4) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(bytes[i], 1'b1, (i == bytes.size() - 1) && !sep_end);
    end
    // a byte-less terminator closes the header
    if (sep_end || bytes.size() == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_text(string s);
    bit [7:0] bytes[$];
    for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
    send_header(bytes, 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  function automatic bit [7:0] blank_char();
    bit [7:0] b;
    b = " ";
    if ($urandom_range(0, 1)) b = "\t";
    return b;
  endfunction

  function automatic void add_blanks(ref bit [7:0] q[$]);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) q.push_back(blank_char());
  endfunction

  function automatic void add_str(ref bit [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_entry(ref bit [7:0] q[$]);
    bit [7:0] tok[$];
    string    name;
    add_blanks(q);
    case ($urandom_range(0, 9))
      0, 1, 2: name = "gzip";
      3, 4, 5: name = "br";
      6, 7:    name = "*";
      8:       name = "x";
      default: name = "";
    endcase
    if (name == "x") begin
      // unknown token, any byte values
      repeat ($urandom_range(1, 8)) tok.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < name.len(); i++) begin
        if (name[i] >= "a" && name[i] <= "z" && $urandom_range(0, 1))
          tok.push_back(name[i] ^ 8'h20);
        else
          tok.push_back(name[i]);
      end
    end
    if (tok.size() > 1 && $urandom_range(0, 7) == 0)
      tok.insert($urandom_range(1, tok.size() - 1), blank_char());
    foreach (tok[i]) q.push_back(tok[i]);
    add_blanks(q);
    repeat ($urandom_range(0, 2)) begin
      q.push_back(";");
      add_blanks(q);
      add_str(q, param_pool[$urandom_range(0, 17)]);
      add_blanks(q);
    end
  endfunction

  function automatic void build_header(ref bit [7:0] q[$]);
    int n;
    q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) q.push_back(",");
      add_entry(q);
    end
    if ($urandom_range(0, 9) == 0) q.push_back(",");
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // hand-picked headers
    hdr.delete();
    send_header(hdr, 1'b1);
    send_text("gZiP");
    send_text("*;q=0,,br");
    send_text("g p;q=");
    send_text("Br;q=1;q=0");

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct = 9;
          dst_idle_pct = 74;
        end
        1: begin
          src_idle_pct = 74;
          dst_idle_pct = 9;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      if (p == 2) begin
        // back-to-back short headers while the output is held off
        hold_reqs++;
        repeat (12) begin
          if ($urandom_range(0, 1)) send_text("br");
          else send_text("gzip;q=0");
        end
      end
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) begin
        build_header(hdr);
        send_header(hdr, $urandom_range(0, 3) == 0);
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
